// File: hdl/pojd_pkg.sv
// ----------------------------------------------------------------------------
// Job dispatcher package
// Shared widths, codes, state type and the command and status words that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package pojd_pkg;

  // Field widths.
  localparam int MODE_W = 2;
  localparam int TIME_W = 32;
  localparam int PER_W  = 16;
  localparam int KIND_W = 2;
  localparam int ID_W   = 4;
  localparam int SI_W   = 8;

  // Table size default and the dispatch limit of one tick.
  localparam int SLOTS_DEF = 16;
  localparam int MAX_OUT   = 16;
  localparam int DISP_W    = $clog2(MAX_OUT + 1);

  // Scan interval after reset.
  localparam logic [SI_W-1:0] SCAN_INTERVAL_RST = SI_W'(5);

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_ONCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_REC  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan_en;
    logic find_en;
    logic flush_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic find_done;
    logic flush_done;
  } status_t;

endpackage

// File: hdl/pojd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module pojd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pojd_ctrl.sv
// ----------------------------------------------------------------------------
// Job dispatcher controller
// Sequences one input word at a time through scan, free-slot search and
// flush of the held result.
// ----------------------------------------------------------------------------
module pojd_ctrl import pojd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  input  status_t           status,
  output cmd_t              cmd,
  output logic              in_stall,
  output logic              cfg_ready
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_TICK) begin
            state_nxt = ST_SCAN;
          end else if (in_mode == MODE_ADD_ONCE || in_mode == MODE_ADD_REC) begin
            state_nxt = ST_FIND;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FIND: begin
        if (status.find_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.flush_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN:  cmd.scan_en  = 1'b1;
      ST_FIND:  cmd.find_en  = 1'b1;
      ST_FLUSH: cmd.flush_en = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: hdl/pojd_dp.sv
// ----------------------------------------------------------------------------
// Job dispatcher datapath
// Slot table, scan pipeline, free-slot search, held result and output word.
// ----------------------------------------------------------------------------
module pojd_dp import pojd_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              cfg_we,
  input  logic [SI_W-1:0]   cfg_scan_interval,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [TIME_W-1:0] in_now_time,
  input  logic [TIME_W-1:0] in_job_time,
  input  logic [PER_W-1:0]  in_job_period,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_job_id,
  output logic              out_is_recurring,
  output logic [TIME_W-1:0] out_due_time,
  output logic              out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Configuration and captured input word.
  logic [SI_W-1:0]   si_r;
  logic [MODE_W-1:0] op_mode_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] lo_r;
  logic [TIME_W-1:0] jtime_r;
  logic [PER_W-1:0]  jper_r;

  // Slot flags and scan control.
  logic              valid_r [SLOTS];
  logic              rec_r   [SLOTS];
  logic [CNT_W-1:0]  rd_idx_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic [DISP_W-1:0] disp_cnt_r;

  // Held result and output word.
  logic              pend_vld_r;
  logic [KIND_W-1:0] pend_kind_r;
  logic [ID_W-1:0]   pend_id_r;
  logic              pend_rec_r;
  logic [TIME_W-1:0] pend_due_r;
  logic              out_vld_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_rec_r;
  logic [TIME_W-1:0] out_due_r;
  logic              out_last_r;

  logic [IDX_W-1:0]  rd_addr;
  logic              rd_more;
  logic [TIME_W-1:0] due_rd;
  logic [PER_W-1:0]  per_rd;
  logic              in_win;
  logic              hit;
  logic              out_free;
  logic              hold;
  logic              adv;
  logic              take_hit;
  logic              scan_rd;
  logic              op_rec;
  logic [TIME_W-1:0] new_due;
  logic              find_done;
  logic              find_take;
  logic              find_ok;
  logic              flush_move;
  logic              due_we;
  logic [IDX_W-1:0]  due_waddr;
  logic [TIME_W-1:0] due_wdata;
  logic [TIME_W-1:0] lo_nxt;

  // Slot due times and periods.
  pojd_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (due_waddr),
    .wdata (due_wdata),
    .re    (scan_rd),
    .raddr (rd_addr),
    .rdata (due_rd)
  );

  pojd_ram #(.WIDTH(PER_W), .DEPTH(SLOTS)) u_per_ram (
    .clk   (clk),
    .we    (find_ok),
    .waddr (rd_addr),
    .wdata (jper_r),
    .re    (scan_rd),
    .raddr (rd_addr),
    .rdata (per_rd)
  );

  // Lower bound of the window, saturating at zero.
  assign lo_nxt = (in_now_time >= TIME_W'(si_r)) ? in_now_time - TIME_W'(si_r) : '0;

  // Scan pipeline: one slot read per cycle while no hit is held by a stalled output, checked in the next.
  assign rd_addr  = rd_idx_r[IDX_W-1:0];
  assign rd_more  = (rd_idx_r != CNT_W'(SLOTS));
  assign in_win   = (due_rd >= lo_r) && (due_rd <= now_r);
  assign hit      = cmd.scan_en && chk_vld_r && valid_r[chk_idx_r] && in_win &&
                    (disp_cnt_r < DISP_W'(MAX_OUT));
  assign out_free = !out_vld_r || !out_stall;
  assign hold     = hit && pend_vld_r && !out_free;
  assign adv      = cmd.scan_en && !hold;
  assign take_hit = hit && !hold;
  assign scan_rd  = adv && rd_more;

  // Free-slot search: one slot flag per cycle.
  assign op_rec    = (op_mode_r == MODE_ADD_REC);
  assign new_due   = op_rec ? now_r + TIME_W'(jper_r) : jtime_r;
  assign find_done = !rd_more || !valid_r[rd_addr];
  assign find_take = cmd.find_en && find_done;
  assign find_ok   = find_take && rd_more;

  // Flush of the held result with the last mark.
  assign flush_move = cmd.flush_en && pend_vld_r && out_free;

  // Due time write: new job, or advance of a dispatched recurring job.
  assign due_we    = (take_hit && rec_r[chk_idx_r]) || find_ok;
  assign due_waddr = find_ok ? rd_addr : chk_idx_r;
  assign due_wdata = find_ok ? new_due : due_rd + TIME_W'(per_rd);

  assign status.scan_done  = !rd_more && !chk_vld_r;
  assign status.find_done  = find_done;
  assign status.flush_done = !pend_vld_r || out_free;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r       <= SCAN_INTERVAL_RST;
      rd_idx_r   <= '0;
      chk_vld_r  <= 1'b0;
      disp_cnt_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i] <= 1'b0;
        rec_r[i]   <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        si_r <= cfg_scan_interval;
      end
      // Counters.
      if (cmd.start) begin
        rd_idx_r   <= '0;
        chk_vld_r  <= 1'b0;
        disp_cnt_r <= '0;
      end else if (adv) begin
        chk_vld_r <= rd_more;
        if (rd_more) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (take_hit) begin
          disp_cnt_r <= disp_cnt_r + DISP_W'(1);
        end
      end else if (cmd.find_en && !find_done) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      // Slot flags.
      if (take_hit && !rec_r[chk_idx_r]) begin
        valid_r[chk_idx_r] <= 1'b0;
      end
      if (find_ok) begin
        valid_r[rd_addr] <= 1'b1;
        rec_r[rd_addr]   <= op_rec;
      end
      // Held result.
      if (take_hit || find_take) begin
        pend_vld_r <= 1'b1;
      end else if (flush_move) begin
        pend_vld_r <= 1'b0;
      end
      // Output word.
      if ((take_hit && pend_vld_r) || flush_move) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_mode_r <= in_mode;
      now_r     <= in_now_time;
      lo_r      <= lo_nxt;
      jtime_r   <= in_job_time;
      jper_r    <= in_job_period;
    end
    if (adv) begin
      chk_idx_r <= rd_addr;
    end
    if (take_hit) begin
      pend_kind_r <= KIND_DISPATCH;
      pend_id_r   <= ID_W'(chk_idx_r);
      pend_rec_r  <= rec_r[chk_idx_r];
      pend_due_r  <= due_rd;
    end else if (find_take) begin
      pend_kind_r <= find_ok ? KIND_ADD_OK : KIND_ADD_FULL;
      pend_id_r   <= find_ok ? ID_W'(rd_addr) : '0;
      pend_rec_r  <= op_rec;
      pend_due_r  <= find_ok ? new_due : '0;
    end
    if ((take_hit && pend_vld_r) || flush_move) begin
      out_kind_r <= pend_kind_r;
      out_id_r   <= pend_id_r;
      out_rec_r  <= pend_rec_r;
      out_due_r  <= pend_due_r;
      out_last_r <= flush_move;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_kind_r;
  assign out_job_id       = out_id_r;
  assign out_is_recurring = out_rec_r;
  assign out_due_time     = out_due_r;
  assign out_last         = out_last_r;

endmodule

// File: hdl/periodic_and_oneshot_job_dispatcher.sv
// ----------------------------------------------------------------------------
// Periodic and one-shot job dispatcher
// Table of job slots: add words store a job in the lowest free slot, tick
// words dispatch each job due within the look-back window, up to MAX_OUT per tick.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  mode, now, job time, job period
//   out_     output     out_valid/out_stall  kind, slot, recurring, due, last
//   cfg_     input      cfg_valid/cfg_ready  scan interval
//
// A tick reads the slot memory one slot a cycle; an add searches the slot flags
// from slot 0 up to the lowest free slot, or through every slot if the table is full.
// One word is taken at a time; results leave through a single output register
// backed by one held result, and a stalled output pauses the scan.
// Synchronous active-low reset empties the table and sets the interval to 5.
// ----------------------------------------------------------------------------
module periodic_and_oneshot_job_dispatcher import pojd_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [TIME_W-1:0] in_now_time,
  input  logic [TIME_W-1:0] in_job_time,
  input  logic [PER_W-1:0]  in_job_period,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_job_id,
  output logic              out_is_recurring,
  output logic [TIME_W-1:0] out_due_time,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SI_W-1:0]   cfg_scan_interval
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  // Sequencer.
  pojd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  // Slot table and result path.
  pojd_dp #(.SLOTS(SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_scan_interval (cfg_scan_interval),
    .in_mode           (in_mode),
    .in_now_time       (in_now_time),
    .in_job_time       (in_job_time),
    .in_job_period     (in_job_period),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_job_id        (out_job_id),
    .out_is_recurring  (out_is_recurring),
    .out_due_time      (out_due_time),
    .out_last          (out_last)
  );

endmodule
